### design/mtwd_pkg.sv
// Shared types, constants and a helper function of the missing-tooth wheel decoder.
package mtwd_pkg;

    // Default wheel geometry and timestamp width
    localparam int TEETH_DEF     = 58;
    localparam int TIME_BITS_DEF = 32;

    // Fixed field widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PCT_W      = 16;
    localparam int SKIP_W     = 8;
    localparam int ERR_W      = 16;
    localparam int RPM_OUT_W  = 24;
    localparam int POS_OUT_W  = 6;
    localparam int RATIO_OUT_W = 32;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 80;
    localparam int POS_EXT_W  = 9;

    // Arithmetic constants
    localparam int RPM_NUM = 10000000;
    localparam int PCT_DIV = 100;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_GAP_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOOTH_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOOTH_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_FOUND = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP      = 3'd5;

    // Register reset values
    localparam logic [PCT_W-1:0]  GAP_MIN_RST   = 16'd200;
    localparam logic [PCT_W-1:0]  GAP_MAX_RST   = 16'd400;
    localparam logic [PCT_W-1:0]  TOOTH_MIN_RST = 16'd20;
    localparam logic [PCT_W-1:0]  TOOTH_MAX_RST = 16'd180;
    localparam logic [PCT_W-1:0]  GAP_FOUND_RST = 16'd200;
    localparam logic [SKIP_W-1:0] SKIP_RST      = 8'd4;

    // Ratio thresholds handed to the sync tracker
    typedef struct packed {
        logic [PCT_W-1:0] gap_min;
        logic [PCT_W-1:0] gap_max;
        logic [PCT_W-1:0] tooth_min;
        logic [PCT_W-1:0] tooth_max;
        logic [PCT_W-1:0] gap_found;
    } t_cfg;

    // Status reported by the sync tracker
    typedef struct packed {
        logic             synced;
        logic [ERR_W-1:0] errors;
    } t_trk_stat;

    // Positions at which the engine speed is refreshed
    function automatic logic is_rpm_pos(input logic [POS_EXT_W-1:0] p);
        return (p == 9'd10) || (p == 9'd25) || (p == 9'd40) || (p == 9'd55);
    endfunction

endpackage

### design/mtwd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mtwd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 58
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/mtwd_sdiv.sv
// Bit-serial restoring divider: one quotient bit per clock cycle.
module mtwd_sdiv #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_busy,
    output logic [W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_div;
    logic [W:0]       rem_sh;
    logic [W:0]       diff;

    // Bring down the next dividend bit and try one subtraction.
    assign rem_sh = {r_rem, r_quo[W-1]};
    assign diff   = rem_sh - {1'b0, r_div};

    // Control state of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Remainder and quotient shift register; the dividend shifts out as the quotient shifts in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (!diff[W]) begin
                r_rem <= diff[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

### design/mtwd_track.sv
// Sync tracker: tooth position, hunting and synced states, revolution and error counts.
module mtwd_track #(
    parameter int TEETH     = 58,
    parameter int TIME_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mtwd_pkg::t_cfg                i_cfg,
    input  logic                          i_skip_load,
    input  logic [mtwd_pkg::SKIP_W-1:0]   i_skip_val,
    input  logic                          i_update,
    input  logic [TIME_BITS-1:0]          i_ratio,
    output logic [$clog2(TEETH)-1:0]      o_position,
    output mtwd_pkg::t_trk_stat           o_stat
);

    import mtwd_pkg::*;

    localparam int POS_W = $clog2(TEETH);

    logic [POS_W-1:0]  r_pos,  n_pos;
    logic              r_syn,  n_syn;
    logic [1:0]        r_rev,  n_rev;
    logic [SKIP_W-1:0] r_skip, n_skip;
    logic [ERR_W-1:0]  r_err,  n_err;
    logic              gap_bad;
    logic              tooth_bad;
    logic              lose;

    // Ratio window checks against the thresholds.
    assign gap_bad = (i_ratio < TIME_BITS'(i_cfg.gap_min)) ||
                     (i_ratio > TIME_BITS'(i_cfg.gap_max));
    assign tooth_bad = (i_ratio < TIME_BITS'(i_cfg.tooth_min)) ||
                       (i_ratio > TIME_BITS'(i_cfg.tooth_max));

    // Sync loss is judged only once two whole revolutions have passed.
    always_comb begin
        lose = 1'b0;
        if (r_rev == 2'd2 && r_syn) begin
            if (r_pos == '0) begin
                lose = gap_bad;
            end else if (r_pos != POS_W'(1) && r_pos != POS_W'(2)) begin
                lose = tooth_bad;
            end
        end
    end

    // Next state for one tooth edge: loss, skip or hunt, then position advance.
    always_comb begin
        n_pos  = r_pos;
        n_syn  = r_syn;
        n_rev  = r_rev;
        n_skip = r_skip;
        n_err  = r_err;
        if (lose) begin
            n_pos = '0;
            n_syn = 1'b0;
            n_rev = 2'd0;
            n_err = r_err + 1'b1;
        end
        if (r_skip != '0) begin
            n_skip = r_skip - 1'b1;
        end else if (!n_syn && i_ratio > TIME_BITS'(i_cfg.gap_found)) begin
            n_pos = '0;
            n_syn = 1'b1;
            n_rev = 2'd0;
        end
        if (n_pos == POS_W'(TEETH - 1)) begin
            n_pos = '0;
            if (n_rev != 2'd2) begin
                n_rev = n_rev + 1'b1;
            end
        end else begin
            n_pos = n_pos + 1'b1;
        end
    end

    // Tracker registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_syn  <= 1'b0;
            r_rev  <= 2'd0;
            r_skip <= SKIP_RST;
            r_err  <= '0;
        end else if (i_update) begin
            r_pos  <= n_pos;
            r_syn  <= n_syn;
            r_rev  <= n_rev;
            r_skip <= n_skip;
            r_err  <= n_err;
        end else if (i_skip_load) begin
            r_skip <= i_skip_val;
        end
    end

    assign o_position    = r_pos;
    assign o_stat.synced = r_syn;
    assign o_stat.errors = r_err;

endmodule

### design/missing_tooth_wheel_decoder.sv
// Top level of the missing-tooth crank wheel decoder.
// Each input beat carries one tooth edge timestamp and yields one output beat with the sync
// state, the tooth position, the period ratio in percent, the engine speed and the sync error
// count. An edge goes from acceptance to its result in these steps: the edge store read,
// forming the periods and starting the dividers, the previous period divided by 100, the
// ratio division on the same bit-serial divider, and the load of the output register once
// it is free. The engine speed division runs on a second bit-serial divider in parallel
// with these. Edges are handled one at a time; the next edge is accepted as soon as the
// previous result is in the output register. The per-position edge store starts empty
// after reset with no clearing pass, and configuration writes are taken on every cycle.
module missing_tooth_wheel_decoder #(
    parameter int TEETH     = mtwd_pkg::TEETH_DEF,
    parameter int TIME_BITS = mtwd_pkg::TIME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [mtwd_pkg::IN_DATA_W-1:0]    i_s_tdata,  // [31:0] tooth_time
    // Output stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [0] in_sync, [6:1] tooth_position, [38:7] period_ratio, [62:39] engine_rpm,
    // [63] rpm_updated, [79:64] sync_errors
    output logic [mtwd_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // Configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mtwd_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [mtwd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import mtwd_pkg::*;

    localparam int POS_W = $clog2(TEETH);
    localparam int RPM_W = (TIME_BITS > RPM_OUT_W) ? TIME_BITS : RPM_OUT_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_CALC  = 6'b000100,
        S_NOM   = 6'b001000,
        S_RATIO = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state                 r_state, n_state;
    t_cfg                   r_cfg;
    logic [TEETH-1:0]       r_valid;
    logic [TIME_BITS-1:0]   r_t;
    logic [POS_W-1:0]       r_pos;
    logic [POS_W-1:0]       r_prev;
    logic [TIME_BITS-1:0]   r_per_cur;
    logic [TIME_BITS-1:0]   r_last_rpm;
    logic                   r_rpm_go;
    logic [RPM_OUT_W-1:0]   r_rpm;
    logic [TIME_BITS-1:0]   r_ratio;
    logic                   r_upd;
    logic                   r_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data;

    logic                   accept;
    logic                   cfg_we;
    logic [TIME_BITS-1:0]   t_in;
    logic [POS_W-1:0]       trk_pos;
    t_trk_stat              trk_stat;
    logic                   trk_update;
    logic [2*TIME_BITS-1:0] ram_rdata;
    logic [TIME_BITS-1:0]   prev_stamp;
    logic [TIME_BITS-1:0]   prev_per;
    logic [TIME_BITS-1:0]   per_cur;
    logic [TIME_BITS-1:0]   rpm_iv;
    logic                   rpm_pos;
    logic                   div_a_start;
    logic [TIME_BITS-1:0]   div_a_dvd;
    logic [TIME_BITS-1:0]   div_a_dvs;
    logic                   div_a_busy;
    logic [TIME_BITS-1:0]   div_a_q;
    logic                   div_b_start;
    logic                   div_b_busy;
    logic [RPM_W-1:0]       div_b_q;
    logic [TIME_BITS-1:0]   nom;
    logic [RPM_OUT_W+1:0]   rpm_x3;
    logic [POS_EXT_W-1:0]   pos_ext;
    logic [POS_EXT_W-1:0]   out_pos_ext;
    logic                   out_free;

    assign accept      = i_s_tvalid && o_s_tready;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign t_in        = TIME_BITS'(i_s_tdata);
    assign out_free    = !r_out_valid || i_m_tready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gap_min   <= GAP_MIN_RST;
            r_cfg.gap_max   <= GAP_MAX_RST;
            r_cfg.tooth_min <= TOOTH_MIN_RST;
            r_cfg.tooth_max <= TOOTH_MAX_RST;
            r_cfg.gap_found <= GAP_FOUND_RST;
        end else if (cfg_we) begin
            case (i_cfg_addr)
                REG_GAP_MIN:   r_cfg.gap_min   <= i_cfg_data;
                REG_GAP_MAX:   r_cfg.gap_max   <= i_cfg_data;
                REG_TOOTH_MIN: r_cfg.tooth_min <= i_cfg_data;
                REG_TOOTH_MAX: r_cfg.tooth_max <= i_cfg_data;
                REG_GAP_FOUND: r_cfg.gap_found <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // Per-position store of edge time (low half) and period (high half).
    mtwd_ram #(
        .WIDTH (2 * TIME_BITS),
        .DEPTH (TEETH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_state == S_CALC),
        .i_waddr (r_pos),
        .i_wdata ({per_cur, r_t}),
        .i_raddr (r_prev),
        .o_rdata (ram_rdata)
    );

    // Entries never written read as zero.
    assign prev_stamp = r_valid[r_prev] ? ram_rdata[TIME_BITS-1:0] : '0;
    assign prev_per   = r_valid[r_prev] ? ram_rdata[2*TIME_BITS-1:TIME_BITS] : '0;
    assign per_cur    = r_t - prev_stamp;
    assign rpm_iv     = r_t - r_last_rpm;
    assign pos_ext    = POS_EXT_W'(r_pos);
    assign rpm_pos    = is_rpm_pos(pos_ext);

    // Shared divider: previous period over 100, then the current period over that share.
    assign div_a_start = (r_state == S_CALC) || (r_state == S_NOM && !div_a_busy);
    assign div_a_dvd   = (r_state == S_CALC) ? prev_per : r_per_cur;
    assign div_a_dvs   = (r_state == S_CALC) ? TIME_BITS'(PCT_DIV) : nom;
    assign nom         = (div_a_q == '0) ? TIME_BITS'(1) : div_a_q;

    mtwd_sdiv #(
        .W (TIME_BITS)
    ) u_div_ratio (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_a_start),
        .i_dividend (div_a_dvd),
        .i_divisor  (div_a_dvs),
        .o_busy     (div_a_busy),
        .o_quotient (div_a_q)
    );

    // Engine speed divider, run only at the refresh positions and when the refresh interval is nonzero.
    assign div_b_start = (r_state == S_CALC) && rpm_pos && (rpm_iv != '0);

    mtwd_sdiv #(
        .W (RPM_W)
    ) u_div_rpm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_b_start),
        .i_dividend (RPM_W'(RPM_NUM)),
        .i_divisor  (RPM_W'(rpm_iv)),
        .o_busy     (div_b_busy),
        .o_quotient (div_b_q)
    );

    // Times six over four is three halves; the quotient never exceeds 24 bits.
    assign rpm_x3 = {2'b00, div_b_q[RPM_OUT_W-1:0]} + {1'b0, div_b_q[RPM_OUT_W-1:0], 1'b0};

    assign trk_update = (r_state == S_RATIO) && !div_a_busy && !div_b_busy;

    mtwd_track #(
        .TEETH     (TEETH),
        .TIME_BITS (TIME_BITS)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_skip_load (cfg_we && i_cfg_addr == REG_SKIP),
        .i_skip_val  (i_cfg_data[SKIP_W-1:0]),
        .i_update    (trk_update),
        .i_ratio     (div_a_q),
        .o_position  (trk_pos),
        .o_stat      (trk_stat)
    );

    // Sequencer for one edge.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_READ;
            S_READ:  n_state = S_CALC;
            S_CALC:  n_state = S_NOM;
            S_NOM:   if (!div_a_busy) n_state = S_RATIO;
            S_RATIO: if (trk_update) n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers: state, store valid bits, last refresh time, engine speed, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_last_rpm  <= '0;
            r_rpm       <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CALC) begin
                r_valid[r_pos] <= 1'b1;
                if (rpm_pos) begin
                    r_last_rpm <= r_t;
                end
            end
            if (trk_update && r_rpm_go) begin
                r_rpm <= rpm_x3[RPM_OUT_W:1];
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Edge payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_t    <= t_in;
            r_pos  <= trk_pos;
            r_prev <= (trk_pos == '0) ? POS_W'(TEETH - 1) : trk_pos - 1'b1;
        end
        if (r_state == S_CALC) begin
            r_per_cur <= per_cur;
            r_rpm_go  <= div_b_start;
        end
        if (trk_update) begin
            r_ratio <= div_a_q;
            r_upd   <= r_rpm_go;
        end
    end

    // Output register, loaded once the previous beat has gone or is taken in the same cycle.
    assign out_pos_ext = POS_EXT_W'(trk_pos);

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_data <= {trk_stat.errors, r_upd, r_rpm, RATIO_OUT_W'(r_ratio),
                           out_pos_ext[POS_OUT_W-1:0], trk_stat.synced};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
